FILE: src/chained_hash_map_lookup_insert_assert.svh
// Assertion macros shared by the hash map modules.
`ifndef CHAINED_HASH_MAP_LOOKUP_INSERT_ASSERT_SVH
`define CHAINED_HASH_MAP_LOOKUP_INSERT_ASSERT_SVH
`ifndef SYNTHESIS
`define CHM_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash map: implication check failed");
`define CHM_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash map: next-cycle check failed");
`define CHM_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("hash map: forbidden condition seen");
`else
`define CHM_IMPL(label, ante, cons)
`define CHM_NEXT(label, ante, cons)
`define CHM_NEVER(label, expr)
`endif
`endif

FILE: src/chmap_pkg.sv
// Types and constants of the chained hash map.
package chmap_pkg;

  localparam int BUCKETS      = 1024;
  localparam int POOL_ENTRIES = 4096;
  localparam int QUEUE_DEPTH  = 2;

  localparam int KEY_W    = 24;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int NODE_W   = $clog2(POOL_ENTRIES);
  localparam int PTR_W    = $clog2(POOL_ENTRIES + 1);

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND   = 2'd0,
    ST_CREATED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;
    logic [BKT_W-1:0]  bucket;
  } q_item_t;

endpackage

FILE: src/chmap_in_if.sv
// Request channel: command, key and value of one access.
interface chmap_in_if import chmap_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] data_in;

  modport source(output valid, command, key, data_in, input ready);
  modport sink(input valid, command, key, data_in, output ready);
endinterface

FILE: src/chmap_out_if.sv
// Response channel: value and status of one access.
interface chmap_out_if import chmap_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;

  modport source(output valid, data_out, status, input ready);
  modport sink(input valid, data_out, status, output ready);
endinterface

FILE: src/chmap_ram.sv
// Generic simple dual-port RAM with registered read data.
module chmap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/chmap_front.sv
// Front end: accepts items, computes the bucket and queues them.
`include "chained_hash_map_lookup_insert_assert.svh"

module chmap_front import chmap_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      hold,
  chmap_in_if.sink  req,
  output q_item_t   q_item,
  output logic      q_valid,
  input  logic      q_pop
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic [KEY_W-1:0]  bkt_full;
  q_item_t           in_item;

  assign req.ready = !hold && (count != QCNT_W'(QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign bkt_full  = req.key % KEY_W'(BUCKETS);

  always_comb begin
    in_item.command = req.command;
    in_item.key     = req.key;
    in_item.data_in = req.data_in;
    in_item.bucket  = bkt_full[BKT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        count <= count + QCNT_W'(1);
      end else if (!push && q_pop) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];

  `CHM_NEVER(a_queue_bound, count > QCNT_W'(QUEUE_DEPTH))
  `CHM_IMPL(a_hold_blocks, hold, !req.ready)
  `CHM_NEXT(a_push_counts, push && !q_pop, count == $past(count) + QCNT_W'(1))

endmodule

FILE: src/chmap_back.sv
// Back end: clears the bucket table, walks chains, appends nodes, returns results.
`include "chained_hash_map_lookup_insert_assert.svh"

module chmap_back import chmap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  q_item_t     q_item,
  input  logic        q_valid,
  output logic        q_pop,
  output logic        clearing,
  chmap_out_if.source rsp
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_HEAD  = 8'b00000100,
    S_WALK  = 8'b00001000,
    S_VREAD = 8'b00010000,
    S_ALLOC = 8'b00100000,
    S_LINK  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t            st;
  state_t            st_next;
  q_item_t           itm;
  logic [PTR_W-1:0]  cur_ptr;
  logic [PTR_W-1:0]  prev_ptr;
  logic [PTR_W-1:0]  nodes_used;
  logic [BKT_W-1:0]  clr_addr;
  logic [DATA_W-1:0] res_data;
  status_t           res_status;
  logic              out_valid;
  logic [DATA_W-1:0] out_data;
  status_t           out_status;

  logic              bkt_we;
  logic [BKT_W-1:0]  bkt_waddr;
  logic [PTR_W-1:0]  bkt_wdata;
  logic [BKT_W-1:0]  bkt_raddr;
  logic [PTR_W-1:0]  bkt_rdata;
  logic              key_we;
  logic [KEY_W-1:0]  key_rdata;
  logic              val_we;
  logic [NODE_W-1:0] val_waddr;
  logic [DATA_W-1:0] val_wdata;
  logic [DATA_W-1:0] val_rdata;
  logic              link_we;
  logic [NODE_W-1:0] link_waddr;
  logic [PTR_W-1:0]  link_wdata;
  logic [PTR_W-1:0]  link_rdata;

  logic [PTR_W-1:0]  walk_ptr;
  logic [PTR_W-1:0]  walk_less;
  logic [PTR_W-1:0]  cur_less;
  logic [PTR_W-1:0]  prev_less;
  logic [NODE_W-1:0] node_raddr;
  logic [NODE_W-1:0] cur_idx;
  logic [NODE_W-1:0] prev_idx;
  logic [NODE_W-1:0] new_idx;
  logic [PTR_W-1:0]  new_ptr;
  logic              pool_full;
  logic              key_hit;
  logic              out_free;
  logic              clr_last;
  logic [DATA_W-1:0] new_value;

  assign walk_ptr   = (st == S_HEAD) ? bkt_rdata : link_rdata;
  assign walk_less  = walk_ptr - PTR_W'(1);
  assign cur_less   = cur_ptr - PTR_W'(1);
  assign prev_less  = prev_ptr - PTR_W'(1);
  assign node_raddr = walk_less[NODE_W-1:0];
  assign cur_idx    = cur_less[NODE_W-1:0];
  assign prev_idx   = prev_less[NODE_W-1:0];
  assign new_idx    = nodes_used[NODE_W-1:0];
  assign new_ptr    = nodes_used + PTR_W'(1);
  assign pool_full  = (nodes_used == PTR_W'(POOL_ENTRIES));
  assign key_hit    = (key_rdata == itm.key);
  assign out_free   = !out_valid || rsp.ready;
  assign clr_last   = (clr_addr == BKT_W'(BUCKETS - 1));
  assign new_value  = (itm.command == CMD_WRITE) ? itm.data_in : '0;
  assign clearing   = (st == S_CLEAR);

  always_comb begin
    st_next    = st;
    q_pop      = 1'b0;
    bkt_we     = 1'b0;
    bkt_waddr  = itm.bucket;
    bkt_wdata  = new_ptr;
    bkt_raddr  = q_item.bucket;
    key_we     = 1'b0;
    val_we     = 1'b0;
    val_waddr  = new_idx;
    val_wdata  = new_value;
    link_we    = 1'b0;
    link_waddr = new_idx;
    link_wdata = '0;
    unique case (st)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_addr;
        bkt_wdata = '0;
        if (clr_last) begin
          st_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          st_next = S_HEAD;
        end
      end
      S_HEAD: begin
        st_next = (bkt_rdata == '0) ? S_ALLOC : S_WALK;
      end
      S_WALK: begin
        if (key_hit) begin
          if (itm.command == CMD_WRITE) begin
            val_we    = 1'b1;
            val_waddr = cur_idx;
            val_wdata = itm.data_in;
            st_next   = S_DONE;
          end else begin
            st_next = S_VREAD;
          end
        end else if (link_rdata == '0) begin
          st_next = S_ALLOC;
        end
      end
      S_VREAD: begin
        st_next = S_DONE;
      end
      S_ALLOC: begin
        if (pool_full) begin
          st_next = S_DONE;
        end else begin
          key_we  = 1'b1;
          val_we  = 1'b1;
          link_we = 1'b1;
          if (prev_ptr == '0) begin
            bkt_we  = 1'b1;
            st_next = S_DONE;
          end else begin
            st_next = S_LINK;
          end
        end
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_idx;
        link_wdata = nodes_used;
        st_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          st_next = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_CLEAR;
      clr_addr   <= '0;
      nodes_used <= '0;
      out_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (st == S_CLEAR) begin
        clr_addr <= clr_addr + BKT_W'(1);
      end
      if (st == S_ALLOC && !pool_full) begin
        nodes_used <= new_ptr;
      end
      if (st == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == S_IDLE && q_valid) begin
      itm <= q_item;
    end
    if (st == S_HEAD) begin
      cur_ptr  <= bkt_rdata;
      prev_ptr <= '0;
    end
    if (st == S_WALK && !key_hit) begin
      prev_ptr <= cur_ptr;
      cur_ptr  <= link_rdata;
    end
    if (st == S_WALK && key_hit && itm.command == CMD_WRITE) begin
      res_data   <= itm.data_in;
      res_status <= ST_FOUND;
    end
    if (st == S_VREAD) begin
      res_data   <= val_rdata;
      res_status <= ST_FOUND;
    end
    if (st == S_ALLOC) begin
      res_data   <= pool_full ? '0 : new_value;
      res_status <= pool_full ? ST_FULL : ST_CREATED;
    end
    if (st == S_DONE && out_free) begin
      out_data   <= res_data;
      out_status <= res_status;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.data_out = out_data;
  assign rsp.status   = out_status;

  chmap_ram #(.WIDTH(PTR_W), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  chmap_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (new_idx),
    .wdata (itm.key),
    .raddr (node_raddr),
    .rdata (key_rdata)
  );

  chmap_ram #(.WIDTH(DATA_W), .DEPTH(POOL_ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (cur_idx),
    .rdata (val_rdata)
  );

  chmap_ram #(.WIDTH(PTR_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (node_raddr),
    .rdata (link_rdata)
  );

  `CHM_NEVER(a_pool_bound, nodes_used > PTR_W'(POOL_ENTRIES))
  `CHM_IMPL(a_full_no_store, st == S_ALLOC && pool_full, !key_we && !link_we && !bkt_we)
  `CHM_IMPL(a_no_pop_clearing, st == S_CLEAR, !q_pop && !out_valid)
  `CHM_NEXT(a_append_links, st == S_ALLOC && !pool_full && prev_ptr != '0, st == S_LINK)

endmodule

FILE: src/chained_hash_map_lookup_insert.sv
// Top level of the chained hash map with lookup and insert.
// A read hit passes S_HEAD, S_WALK, S_VREAD and S_DONE; a write hit skips S_VREAD;
// each further node adds a pass of S_WALK; an insert goes from S_ALLOC, through S_LINK
// when appending, to S_DONE. One item is walked at a time while the front queue holds up
// to 2 more; the chain walk sets the rate. After reset the 1024-entry bucket table is
// swept clear, one entry a cycle, and no item is accepted while it is cleared.
module chained_hash_map_lookup_insert import chmap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  chmap_in_if.sink    req,
  chmap_out_if.source rsp
);

  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;
  logic    clearing;

  chmap_front u_front (
    .clk     (clk),
    .rst     (rst),
    .hold    (clearing),
    .req     (req),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  chmap_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the chained hash map: directed accesses, random traffic, stalls.
module tb_top;
  import chmap_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
  } map_result_t;

  typedef struct packed {
    logic              command;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data_in;
    bit                typed;
    logic [DATA_W-1:0] exp_data;
    status_t           exp_status;
  } access_row_t;

  logic clk;
  logic rst;

  chmap_in_if  req_if ();
  chmap_out_if rsp_if ();

  chained_hash_map_lookup_insert dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [PTR_W-1:0]  head_tbl      [BUCKETS];
  logic [KEY_W-1:0]  node_key_tbl  [POOL_ENTRIES];
  logic [DATA_W-1:0] node_val_tbl  [POOL_ENTRIES];
  logic [PTR_W-1:0]  node_link_tbl [POOL_ENTRIES];
  int unsigned       nodes_alloc;

  map_result_t       pending_results [$];
  logic [KEY_W-1:0]  known_keys [$];
  access_row_t       directed_rows [19];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned full_seen;
  int unsigned mismatches;

  function automatic map_result_t access_map(input logic cmd, input logic [KEY_W-1:0] key,
                                             input logic [DATA_W-1:0] din);
    int unsigned bkt;
    int unsigned cur;
    int unsigned prev;
    int unsigned steps;
    map_result_t res;
    bkt = key % BUCKETS;
    cur = head_tbl[bkt];
    prev = 0;
    steps = 0;
    while (cur != 0 && cur <= POOL_ENTRIES && steps < POOL_ENTRIES) begin
      if (node_key_tbl[cur-1] == key) break;
      prev = cur;
      cur = node_link_tbl[cur-1];
      steps++;
    end
    if (cur > POOL_ENTRIES || steps >= POOL_ENTRIES) cur = 0;
    if (cur != 0) begin
      if (cmd == CMD_WRITE) node_val_tbl[cur-1] = din;
      res.data = node_val_tbl[cur-1];
      res.status = ST_FOUND;
    end else if (nodes_alloc >= POOL_ENTRIES) begin
      res.data = '0;
      res.status = ST_FULL;
    end else begin
      node_key_tbl[nodes_alloc] = key;
      node_val_tbl[nodes_alloc] = (cmd == CMD_WRITE) ? din : '0;
      node_link_tbl[nodes_alloc] = '0;
      if (prev != 0) node_link_tbl[prev-1] = PTR_W'(nodes_alloc + 1);
      else head_tbl[bkt] = PTR_W'(nodes_alloc + 1);
      res.data = node_val_tbl[nodes_alloc];
      res.status = ST_CREATED;
      nodes_alloc++;
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    int unsigned raw;
    sel = $urandom_range(99);
    if (sel < 40 && known_keys.size() != 0)
      return known_keys[$urandom_range(known_keys.size() - 1)];
    if (sel < 60) raw = $urandom_range(47) * BUCKETS + ((sel % 2 == 0) ? 3 : BUCKETS - 1);
    else raw = $urandom;
    return raw[KEY_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function automatic logic pick_command();
    return $urandom_range(1) ? CMD_WRITE : CMD_READ;
  endfunction

  function automatic void check_result(input logic [DATA_W-1:0] data,
                                       input logic [STATUS_W-1:0] status);
    map_result_t want;
    results_seen++;
    if (status == ST_FULL) full_seen++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, got data %h status %0d",
               $time, data, status);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (data !== want.data) begin
      $display("%0t: data_out mismatch, expected %h, got %h", $time, want.data, data);
      mismatches++;
    end
    if (status !== want.status) begin
      $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
      mismatches++;
    end
  endfunction

  task automatic issue(input logic cmd, input logic [KEY_W-1:0] key,
                       input logic [DATA_W-1:0] din, input bit typed,
                       input logic [DATA_W-1:0] t_data, input status_t t_status);
    map_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.key     <= key;
    req_if.data_in <= din;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    res = access_map(cmd, key, din);
    if (res.status == ST_CREATED) known_keys.push_back(key);
    if (typed) begin
      res.data = t_data;
      res.status = t_status;
    end
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic issue_random(input logic [KEY_W-1:0] key);
    issue(pick_command(), key, pick_data(), 1'b0, '0, ST_FOUND);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        check_result(rsp_if.data_out, rsp_if.status);
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] k;
    rst <= 1'b1;
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_READ;
    req_if.key     <= '0;
    req_if.data_in <= '0;
    hold_request = 1'b0;
    nodes_alloc = 0;
    items_sent = 0;
    results_seen = 0;
    full_seen = 0;
    mismatches = 0;
    for (int i = 0; i < BUCKETS; i++) head_tbl[i] = '0;
    directed_rows = '{
      '{CMD_READ,  24'h000000, 32'h00000000, 1'b1, 32'h00000000, ST_CREATED},
      '{CMD_WRITE, 24'h000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, ST_FOUND},
      '{CMD_READ,  24'h000000, 32'h13572468, 1'b1, 32'hFFFFFFFF, ST_FOUND},
      '{CMD_WRITE, 24'hFFFFFF, 32'h00000000, 1'b1, 32'h00000000, ST_CREATED},
      '{CMD_WRITE, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, ST_FOUND},
      '{CMD_WRITE, 24'h000400, 32'h12345678, 1'b1, 32'h12345678, ST_CREATED},
      '{CMD_READ,  24'h000800, 32'hFFFFFFFF, 1'b1, 32'h00000000, ST_CREATED},
      '{CMD_READ,  24'h000400, 32'h00000000, 1'b1, 32'h12345678, ST_FOUND},
      '{CMD_WRITE, 24'h000800, 32'hA5A5A5A5, 1'b1, 32'hA5A5A5A5, ST_FOUND},
      '{CMD_READ,  24'h000000, 32'h00000000, 1'b1, 32'hFFFFFFFF, ST_FOUND},
      '{CMD_WRITE, 24'hFFFC00, 32'h5A5A5A5A, 1'b1, 32'h5A5A5A5A, ST_CREATED},
      '{CMD_READ,  24'h000800, 32'h00000000, 1'b1, 32'hA5A5A5A5, ST_FOUND},
      '{CMD_WRITE, 24'h7FFFFF, 32'h80000000, 1'b1, 32'h80000000, ST_CREATED},
      '{CMD_READ,  24'hFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF, ST_FOUND},
      '{CMD_WRITE, 24'h800000, 32'h00000001, 1'b1, 32'h00000001, ST_CREATED},
      '{CMD_READ,  24'h123456, 32'h00000000, 1'b0, 32'h00000000, ST_FOUND},
      '{CMD_WRITE, 24'h123456, 32'hDEADBEEF, 1'b0, 32'h00000000, ST_FOUND},
      '{CMD_READ,  24'h123456, 32'h00000000, 1'b0, 32'h00000000, ST_FOUND},
      '{CMD_WRITE, 24'h000001, 32'h00000000, 1'b1, 32'h00000000, ST_CREATED}
    };
    send_idle_pct = 36;
    recv_idle_pct = 66;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue(directed_rows[i].command, directed_rows[i].key, directed_rows[i].data_in,
            directed_rows[i].typed, directed_rows[i].exp_data, directed_rows[i].exp_status);
    repeat (400) issue_random(pick_key());

    send_idle_pct = 66;
    recv_idle_pct = 36;
    repeat (400) issue_random(pick_key());

    // The receiver holds off for a long stretch here while items keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 1'b1;
    repeat (300) issue_random(pick_key());

    // A last mix of hits on known keys and fresh keys.
    repeat (40) begin
      if ($urandom_range(1) == 0) k = known_keys[$urandom_range(known_keys.size() - 1)];
      else k = KEY_W'($urandom);
      issue_random(k);
    end

    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d accesses under three idle mixes and one long response stall;",
             items_sent);
    $display("checked %0d results, pool grew to %0d nodes, %0d pool-full responses.",
             results_seen, nodes_alloc, full_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: chained_hash_map_lookup_insert.f
+incdir+src
src/chmap_pkg.sv
src/chmap_in_if.sv
src/chmap_out_if.sv
src/chmap_ram.sv
src/chmap_front.sv
src/chmap_back.sv
src/chained_hash_map_lookup_insert.sv
dv/tb_top.sv
